### hdl/pdc_pkg.sv
package pdc_pkg;

  // Request types carried by req_type.
  localparam logic [1:0] REQ_CMD  = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Command byte, top two bits.
  localparam logic [1:0] CMD_SET_X = 2'd0;
  localparam logic [1:0] CMD_SET_Y = 2'd1;
  localparam logic [1:0] CMD_GROUP = 2'd2;

  // Group command codes, low three bits of the command byte.
  localparam logic [2:0] GRP_DEC_Y    = 3'd0;
  localparam logic [2:0] GRP_SCAN_OFF = 3'd1;
  localparam logic [2:0] GRP_SET      = 3'd2;
  localparam logic [2:0] GRP_CLR      = 3'd3;
  localparam logic [2:0] GRP_SET_INC  = 3'd4;
  localparam logic [2:0] GRP_CLR_INC  = 3'd5;
  localparam logic [2:0] GRP_SCAN_ON  = 3'd6;
  localparam logic [2:0] GRP_DEC_X    = 3'd7;

  localparam logic [7:0] FRAMES_MAX = 8'd200;
  localparam logic [7:0] FADE_RESET = 8'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic commit;
    logic clear;
  } pdc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic slot_free;
  } pdc_stat_t;

endpackage

### hdl/pdc_ctrl.sv
module pdc_ctrl
  import pdc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pdc_stat_t stat_i,
  output pdc_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The result is committed only once the output register can take it.
        if (stat_i.slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_accept_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_EXEC))
    else $error("accepted transaction did not move to execute");

  a_commit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> stat_i.slot_free)
    else $error("commit while output register is occupied");
`endif

endmodule

### hdl/pdc_datapath.sv
module pdc_datapath
  import pdc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pdc_cmd_t   cmd_i,
  output pdc_stat_t  stat_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] cmd_byte_i,
  input  logic [8:0] read_address_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_fade_frames_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       video_visible_o,
  output logic       scan_running_o,
  output logic [5:0] cursor_x_o,
  output logic [5:0] cursor_y_o
);

  logic [7:0] mem [512];
  logic [7:0] rdata_q;

  logic [8:0] clr_q;
  logic [7:0] fade_q;
  logic [5:0] x_q, x_d;
  logic [5:0] y_q, y_d;
  logic       scan_q, scan_d;
  logic [7:0] frames_q, frames_d;
  logic       out_valid_q;

  logic [1:0] req_q;
  logic [7:0] cmd_q;

  logic       pix_we;
  logic       pix_set;
  logic [5:0] x_inc;
  logic [7:0] mask;
  logic [8:0] pix_addr;
  logic [8:0] raddr;
  logic       mem_we;
  logic [8:0] waddr;
  logic [7:0] wdata;
  logic       visible;
  logic [7:0] result_data;

  assign pix_addr = {y_q, x_q[5:3]};
  assign raddr    = (req_type_i == REQ_READ) ? read_address_i : pix_addr;
  assign x_inc    = x_q + 6'd1;
  assign mask     = 8'h80 >> x_q[2:0];

  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    scan_d   = scan_q;
    frames_d = frames_q;
    pix_we   = 1'b0;
    pix_set  = 1'b0;
    if (cmd_i.commit) begin
      case (req_q)
        REQ_CMD: begin
          if (scan_q) begin
            if ((cmd_q[7:6] == CMD_GROUP) && (cmd_q[2:0] == GRP_SCAN_OFF)) begin
              scan_d = 1'b0;
            end
          end else begin
            case (cmd_q[7:6])
              CMD_SET_X: x_d = cmd_q[5:0];
              CMD_SET_Y: y_d = cmd_q[5:0];
              CMD_GROUP: begin
                case (cmd_q[2:0])
                  GRP_DEC_Y:    y_d = y_q - 6'd1;
                  GRP_SCAN_OFF: ;
                  GRP_SET: begin
                    pix_we  = 1'b1;
                    pix_set = 1'b1;
                  end
                  GRP_CLR: pix_we = 1'b1;
                  GRP_SET_INC: begin
                    pix_we  = 1'b1;
                    pix_set = 1'b1;
                    x_d     = x_inc;
                    if (x_inc == 6'd0) begin
                      y_d = y_q + 6'd1;
                    end
                  end
                  GRP_CLR_INC: begin
                    pix_we = 1'b1;
                    x_d    = x_inc;
                    if (x_inc == 6'd0) begin
                      y_d = y_q + 6'd1;
                    end
                  end
                  GRP_SCAN_ON: scan_d = 1'b1;
                  GRP_DEC_X: begin
                    x_d = x_q - 6'd1;
                    if (x_q == 6'd0) begin
                      y_d = y_q - 6'd1;
                    end
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end
        REQ_TICK: begin
          if (scan_q) begin
            frames_d = 8'd0;
          end else if (frames_q < FRAMES_MAX) begin
            frames_d = frames_q + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign visible     = (frames_d <= fade_q);
  assign result_data = ((req_q == REQ_READ) && visible) ? rdata_q : 8'h00;

  // The clearing pass after reset and the pixel read-modify-write share one write port.
  assign mem_we = cmd_i.clear | pix_we;
  assign waddr  = cmd_i.clear ? clr_q : pix_addr;
  assign wdata  = cmd_i.clear ? 8'h00 : (pix_set ? (rdata_q | mask) : (rdata_q & ~mask));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.accept) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_type_i;
      cmd_q <= cmd_byte_i;
    end
    if (cmd_i.commit) begin
      read_data_o     <= result_data;
      video_visible_o <= visible;
      scan_running_o  <= scan_d;
      cursor_x_o      <= x_d;
      cursor_y_o      <= y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      fade_q      <= FADE_RESET;
      x_q         <= '0;
      y_q         <= '0;
      scan_q      <= 1'b0;
      frames_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + 9'd1;
      end
      if (cfg_we_i) begin
        fade_q <= cfg_fade_frames_i;
      end
      x_q      <= x_d;
      y_q      <= y_d;
      scan_q   <= scan_d;
      frames_q <= frames_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.clear_done = &clr_q;
  assign stat_o.slot_free  = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;

`ifndef SYNTH
  a_frames_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q <= FRAMES_MAX)
    else $error("frame count above its saturation limit");

  a_scan_locks_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && scan_q) |=> ($stable(x_q) && $stable(y_q)))
    else $error("cursor moved while the scan was running");

  a_commit_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not held in the output register");
`endif

endmodule

### hdl/plot_display_controller.sv
// A result enters the output register when its execute state commits it, after the
// accept; a stalled output register holds the item in the execute state.
// A new item is accepted only after the previous one is committed (accept with the pixel
// memory read, then execute with the write-back of the read-modify-write).
// Reset: asynchronous, active low; cursor, scan and frame count clear, fade limit is 5.
// After reset a clearing pass zeroes all 512 bytes of pixel memory; no item is accepted
// during it, while configuration writes are taken at any time.
module plot_display_controller
  import pdc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] cmd_byte_i,
  input  logic [8:0] read_address_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       video_visible_o,
  output logic       scan_running_o,
  output logic [5:0] cursor_x_o,
  output logic [5:0] cursor_y_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_fade_frames_i
);

  pdc_cmd_t  cmd;
  pdc_stat_t stat;

  assign cfg_ready_o = 1'b1;

  pdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pdc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .req_type_i        (req_type_i),
    .cmd_byte_i        (cmd_byte_i),
    .read_address_i    (read_address_i),
    .cfg_we_i          (cfg_valid_i & cfg_ready_o),
    .cfg_fade_frames_i (cfg_fade_frames_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_data_o       (read_data_o),
    .video_visible_o   (video_visible_o),
    .scan_running_o    (scan_running_o),
    .cursor_x_o        (cursor_x_o),
    .cursor_y_o        (cursor_y_o)
  );

endmodule

### tb/sv/plot_display_controller_checker.sv
`timescale 1ns / 1ps

module plot_display_controller_checker
  import pdc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] req_type_i,
  input  logic [7:0] cmd_byte_i,
  input  logic [8:0] read_address_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] read_data_i,
  input  logic       video_visible_i,
  input  logic       scan_running_i,
  input  logic [5:0] cursor_x_i,
  input  logic [5:0] cursor_y_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [7:0] cfg_fade_frames_i,
  output int         outstanding_o,
  output int         mismatches_o
);

  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [7:0] data;
    logic       visible;
    logic       scanning;
    logic [5:0] x;
    logic [5:0] y;
  } plot_status_t;

  // Shadow copy of the display state.
  logic [7:0] pixel_mem [512];
  logic [5:0] cur_x;
  logic [5:0] cur_y;
  logic       scan_active;
  logic [7:0] frames_since_off;
  logic [7:0] fade_limit;

  plot_status_t expected_status_q [$];

  initial begin
    outstanding_o = 0;
    mismatches_o  = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches_o < MAX_PRINTED) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatches_o++;
  endtask

  function automatic plot_status_t predict_status(input logic [1:0] req,
                                                  input logic [7:0] cmd,
                                                  input logic [8:0] addr);
    logic [2:0]   code;
    logic [8:0]   pix_addr;
    logic [7:0]   pix_mask;
    plot_status_t status;
    code = cmd[2:0];
    if (req == REQ_CMD) begin
      if (scan_active) begin
        // While the scan runs only the scan-off code gets through.
        if (cmd[7:6] == CMD_GROUP && code == GRP_SCAN_OFF) begin
          scan_active = 1'b0;
        end
      end else begin
        case (cmd[7:6])
          CMD_SET_X: cur_x = cmd[5:0];
          CMD_SET_Y: cur_y = cmd[5:0];
          CMD_GROUP: begin
            case (code)
              GRP_DEC_Y: cur_y = cur_y - 6'd1;
              GRP_SET, GRP_CLR, GRP_SET_INC, GRP_CLR_INC: begin
                pix_addr = {cur_y, cur_x[5:3]};
                pix_mask = 8'h80 >> cur_x[2:0];
                if (code == GRP_SET || code == GRP_SET_INC) begin
                  pixel_mem[pix_addr] = pixel_mem[pix_addr] | pix_mask;
                end else begin
                  pixel_mem[pix_addr] = pixel_mem[pix_addr] & ~pix_mask;
                end
                if (code == GRP_SET_INC || code == GRP_CLR_INC) begin
                  cur_x = cur_x + 6'd1;
                  if (cur_x == 6'd0) begin
                    cur_y = cur_y + 6'd1;
                  end
                end
              end
              GRP_SCAN_ON: scan_active = 1'b1;
              GRP_DEC_X: begin
                if (cur_x == 6'd0) begin
                  cur_y = cur_y - 6'd1;
                end
                cur_x = cur_x - 6'd1;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end else if (req == REQ_TICK) begin
      if (scan_active) begin
        frames_since_off = 8'd0;
      end else if (frames_since_off < FRAMES_MAX) begin
        frames_since_off = frames_since_off + 8'd1;
      end
    end
    status.visible  = (frames_since_off <= fade_limit);
    status.data     = (req == REQ_READ && status.visible) ? pixel_mem[addr] : 8'd0;
    status.scanning = scan_active;
    status.x        = cur_x;
    status.y        = cur_y;
    return status;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    plot_status_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 512; i++) begin
        pixel_mem[i] = 8'd0;
      end
      cur_x            = 6'd0;
      cur_y            = 6'd0;
      scan_active      = 1'b0;
      frames_since_off = 8'd0;
      fade_limit       = FADE_RESET;
      expected_status_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        fade_limit = cfg_fade_frames_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_status_q.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_status_q.pop_front();
          if (read_data_i !== want.data) begin
            report_mismatch($sformatf("read_data got %02h expected %02h",
                                      read_data_i, want.data));
          end
          if (video_visible_i !== want.visible) begin
            report_mismatch($sformatf("video_visible got %b expected %b",
                                      video_visible_i, want.visible));
          end
          if (scan_running_i !== want.scanning) begin
            report_mismatch($sformatf("scan_running got %b expected %b",
                                      scan_running_i, want.scanning));
          end
          if (cursor_x_i !== want.x) begin
            report_mismatch($sformatf("cursor_x got %0d expected %0d",
                                      cursor_x_i, want.x));
          end
          if (cursor_y_i !== want.y) begin
            report_mismatch($sformatf("cursor_y got %0d expected %0d",
                                      cursor_y_i, want.y));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_status_q.push_back(predict_status(req_type_i, cmd_byte_i,
                                                   read_address_i));
      end
      outstanding_o <= expected_status_q.size();
    end
  end

endmodule

### tb/sv/plot_display_controller_tb.sv
`timescale 1ns / 1ps

module plot_display_controller_tb;
  import pdc_pkg::*;

  localparam logic [1:0] REQ_NOP      = 2'd3;
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int         HOLD_CYCLES  = 80;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [1:0] req_type_i     = REQ_CMD;
  logic [7:0] cmd_byte_i     = 8'd0;
  logic [8:0] read_address_i = 9'd0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [7:0] read_data_o;
  logic       video_visible_o;
  logic       scan_running_o;
  logic [5:0] cursor_x_o;
  logic [5:0] cursor_y_o;
  logic       cfg_valid_i       = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_fade_frames_i = 8'd0;

  int outstanding;
  int mismatches;

  bit idle_en      = 1'b1;
  bit hold_request = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  plot_display_controller u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .cmd_byte_i        (cmd_byte_i),
    .read_address_i    (read_address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_data_o       (read_data_o),
    .video_visible_o   (video_visible_o),
    .scan_running_o    (scan_running_o),
    .cursor_x_o        (cursor_x_o),
    .cursor_y_o        (cursor_y_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_fade_frames_i (cfg_fade_frames_i)
  );

  plot_display_controller_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .req_type_i        (req_type_i),
    .cmd_byte_i        (cmd_byte_i),
    .read_address_i    (read_address_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_data_i       (read_data_o),
    .video_visible_i   (video_visible_o),
    .scan_running_i    (scan_running_o),
    .cursor_x_i        (cursor_x_o),
    .cursor_y_i        (cursor_y_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_fade_frames_i (cfg_fade_frames_i),
    .outstanding_o     (outstanding),
    .mismatches_o      (mismatches)
  );

  // Offers one request and returns at the edge where the transaction completes.
  task automatic send_item(input logic [1:0] req, input logic [7:0] cmd,
                           input logic [8:0] addr);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    cmd_byte_i     <= cmd;
    read_address_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Dense mode keeps set-Y commands and the reads in the first four rows so
  // that reads land on pixels that were drawn.
  task automatic send_random_op(input int tick_pct, input int cmd_pct, input bit dense);
    int         r;
    int         g;
    logic [2:0] code;
    logic [7:0] cmd;
    logic [8:0] addr;
    r    = $urandom_range(0, 99);
    addr = dense ? 9'($urandom_range(0, 31)) : 9'($urandom);
    cmd  = 8'($urandom);
    if (r < tick_pct) begin
      send_item(REQ_TICK, cmd, addr);
    end else if (r < tick_pct + cmd_pct) begin
      g = $urandom_range(0, 99);
      if (g < 20) begin
        cmd = {CMD_SET_X, 6'($urandom)};
      end else if (g < 35) begin
        cmd = {CMD_SET_Y, dense ? 6'($urandom_range(0, 3)) : 6'($urandom)};
      end else if (g < 92) begin
        g = $urandom_range(0, 99);
        if (g < 3) begin
          code = GRP_SCAN_ON;
        end else if (g < 11) begin
          code = GRP_SCAN_OFF;
        end else begin
          code = 3'($urandom_range(0, 7));
          if (code == GRP_SCAN_ON || code == GRP_SCAN_OFF) begin
            code = GRP_SET_INC;
          end
        end
        cmd = {CMD_GROUP, 3'($urandom), code};
      end else begin
        cmd = {CMD_RESERVED, 6'($urandom)};
      end
      send_item(REQ_CMD, cmd, addr);
    end else if (r < 99) begin
      send_item(REQ_READ, cmd, addr);
    end else begin
      send_item(REQ_NOP, cmd, addr);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_fade(input logic [7:0] value);
    cfg_valid_i       <= 1'b1;
    cfg_fade_frames_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Cursor wrap in both directions, pixel set and clear at the last byte.
    send_item(REQ_READ, 8'($urandom), 9'd0);
    send_item(REQ_CMD, {CMD_SET_X, 6'h3F}, 9'($urandom));
    send_item(REQ_CMD, {CMD_SET_Y, 6'h3F}, 9'($urandom));
    send_item(REQ_CMD, {CMD_GROUP, 3'd0, GRP_SET}, 9'($urandom));
    send_item(REQ_READ, 8'($urandom), 9'd511);
    send_item(REQ_CMD, {CMD_GROUP, 3'd0, GRP_SET_INC}, 9'($urandom));
    send_item(REQ_CMD, {CMD_GROUP, 3'd0, GRP_DEC_X}, 9'($urandom));
    send_item(REQ_CMD, {CMD_GROUP, 3'd0, GRP_CLR}, 9'($urandom));
    send_item(REQ_READ, 8'($urandom), 9'd511);
    send_item(REQ_CMD, {CMD_GROUP, 3'd0, GRP_CLR_INC}, 9'($urandom));
    send_item(REQ_CMD, {CMD_GROUP, 3'd7, GRP_SET}, 9'($urandom));
    send_item(REQ_READ, 8'($urandom), 9'd0);
    send_item(REQ_CMD, {CMD_GROUP, 3'd0, GRP_DEC_Y}, 9'($urandom));
    // Ignored commands: reserved top bits, and scan off while already off.
    send_item(REQ_CMD, {CMD_RESERVED, 6'h2A}, 9'($urandom));
    send_item(REQ_CMD, {CMD_GROUP, 3'd0, GRP_SCAN_OFF}, 9'($urandom));
    // While scanning, every command but scan off is locked out.
    send_item(REQ_CMD, {CMD_GROUP, 3'd0, GRP_SCAN_ON}, 9'($urandom));
    send_item(REQ_CMD, {CMD_SET_X, 6'h05}, 9'($urandom));
    send_item(REQ_CMD, {CMD_GROUP, 3'd0, GRP_SET_INC}, 9'($urandom));
    send_item(REQ_TICK, 8'($urandom), 9'($urandom));
    send_item(REQ_READ, 8'($urandom), 9'd0);
    send_item(REQ_CMD, {CMD_GROUP, 3'd5, GRP_SCAN_OFF}, 9'($urandom));
    send_item(REQ_NOP, 8'($urandom), 9'($urandom));
    // Enough frame ticks to pass the reset fade limit, then an invisible read.
    repeat (6) send_item(REQ_TICK, 8'($urandom), 9'($urandom));
    send_item(REQ_READ, 8'($urandom), 9'd0);
    drain_results();

    // Zero fade limit, starting with a long result-side hold-off.
    write_fade(8'd0);
    hold_request = 1'b1;
    repeat (120) send_random_op(12, 50, 1'b1);
    drain_results();

    // Maximum fade limit with a long run of mostly ticks that drives the count toward saturation.
    write_fade(FRAMES_MAX);
    send_item(REQ_CMD, {CMD_GROUP, 3'($urandom), GRP_SCAN_OFF}, 9'($urandom));
    repeat (210) send_random_op(92, 0, 1'b1);
    drain_results();

    write_fade(8'($urandom_range(0, 199)));
    repeat (150) send_random_op(12, 50, 1'b0);
    drain_results();

    idle_en = 1'b0;
    write_fade(FADE_RESET);
    repeat (120) send_random_op(12, 50, 1'b1);
    drain_results();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hdl/pdc_pkg.sv
hdl/pdc_ctrl.sv
hdl/pdc_datapath.sv
hdl/plot_display_controller.sv
tb/sv/plot_display_controller_checker.sv
tb/sv/plot_display_controller_tb.sv
